@@ rtl/rte_pkg.sv @@
// Shared types, constants and the character classifier for the text run extractor.
package rte_pkg;

    // Widths of reported fields.
    localparam int ADDR_OUT_W = 16;
    localparam int CHAR_W     = 8;
    localparam int MIN_LEN_W  = 7;
    // Wide enough for a run length at the largest supported buffer depth.
    localparam int CNT_W      = 12;
    localparam int TDATA_W    = 40;

    localparam logic [CHAR_W-1:0] SPACE_CH    = 8'h20;
    localparam logic [CHAR_W-1:0] FILL_CH     = 8'h5F;
    localparam logic [CHAR_W-1:0] BLANK_IN_RUN = 8'hFF;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 7'd4;

    typedef enum logic
    {
        KIND_RUN      = 1'b0,
        KIND_OVERFLOW = 1'b1
    } rte_kind_t;

    // One report handed from the front end to the readout side.
    typedef struct packed
    {
        rte_kind_t             kind;
        logic                  bank;
        logic [CNT_W-1:0]      count;
        logic [ADDR_OUT_W-1:0] start_addr;
        logic [ADDR_OUT_W-1:0] end_addr;
    } rte_job_t;

    // Release of a buffer bank once its report has been read out.
    typedef struct packed
    {
        logic valid;
        logic bank;
    } rte_free_t;

    function automatic logic is_text(input logic [CHAR_W-1:0] c);
        logic hit;
        hit = c inside {[8'h30:8'h39], [8'h41:8'h5A], 8'h20, 8'h2D, 8'h3A, 8'h21,
                        8'h2C, 8'h2E, 8'h27, 8'h22, 8'h25};
        return hit;
    endfunction

endpackage

@@ rtl/rte_front.sv @@
// Front end: classifies input bytes, tracks runs and fills the run buffer banks.
module rte_front
    import rte_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int ADDR_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [CHAR_W-1:0]            s_tdata,
    input  logic                         cfg_we,
    input  logic [MIN_LEN_W-1:0]         cfg_wdata,
    output logic                         wr_en,
    output logic [$clog2(MAX_LEN):0]     wr_addr,
    output logic [CHAR_W-1:0]            wr_data,
    output logic                         q_push,
    output rte_job_t                     q_job,
    input  logic                         q_full,
    input  rte_free_t                    bank_free
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CMP_W = (IDX_W > MIN_LEN_W) ? IDX_W : MIN_LEN_W;
    localparam int AW_W  = (ADDR_BITS > ADDR_OUT_W) ? ADDR_BITS : ADDR_OUT_W;

    logic [MIN_LEN_W-1:0] min_len_reg;
    logic [ADDR_BITS-1:0] position_reg, position_next;
    logic                 in_run_reg, in_run_next;
    logic [IDX_W-1:0]     run_length_reg, run_length_next;
    logic [ADDR_BITS-1:0] run_start_reg, run_start_next;
    logic                 halted_reg, halted_next;
    logic                 bank_reg, bank_next;
    logic [1:0]           busy_reg, busy_next;

    logic [CHAR_W-1:0]    c_eff;
    logic                 txt;
    logic                 accept;
    logic [ADDR_BITS-1:0] start_now;
    logic [ADDR_BITS-1:0] end_pos;
    logic [AW_W-1:0]      start_wide, end_wide, pos_wide;

    always_comb
    begin
        c_eff = (in_run_reg && (s_tdata == BLANK_IN_RUN)) ? SPACE_CH : s_tdata;
        txt   = is_text(c_eff);

        s_tready = halted_reg || (!busy_reg[bank_reg] && !q_full);
        accept   = s_tvalid && s_tready && !halted_reg;

        start_now  = in_run_reg ? run_start_reg : position_reg;
        end_pos    = position_reg - ADDR_BITS'(1);
        start_wide = AW_W'(start_now);
        end_wide   = AW_W'(end_pos);
        pos_wide   = AW_W'(position_reg);

        wr_en   = accept && txt;
        wr_addr = {bank_reg, run_length_reg};
        wr_data = c_eff;

        q_push           = 1'b0;
        q_job.kind       = KIND_RUN;
        q_job.bank       = bank_reg;
        q_job.count      = CNT_W'(run_length_reg);
        q_job.start_addr = start_wide[ADDR_OUT_W-1:0];
        q_job.end_addr   = end_wide[ADDR_OUT_W-1:0];

        position_next   = position_reg;
        in_run_next     = in_run_reg;
        run_length_next = run_length_reg;
        run_start_next  = run_start_reg;
        halted_next     = halted_reg;
        bank_next       = bank_reg;
        busy_next       = busy_reg;

        if (bank_free.valid)
        begin
            busy_next[bank_free.bank] = 1'b0;
        end

        if (accept)
        begin
            position_next = position_reg + ADDR_BITS'(1);
            if (txt)
            begin
                run_length_next = run_length_reg + IDX_W'(1);
                run_start_next  = start_now;
                in_run_next     = 1'b1;
                if (run_length_reg == IDX_W'(MAX_LEN - 1))
                begin
                    q_push         = 1'b1;
                    q_job.kind     = KIND_OVERFLOW;
                    q_job.end_addr = pos_wide[ADDR_OUT_W-1:0];
                    halted_next    = 1'b1;
                end
            end
            else if (in_run_reg)
            begin
                in_run_next     = 1'b0;
                run_length_next = '0;
                if (CMP_W'(run_length_reg) >= CMP_W'(min_len_reg))
                begin
                    q_push              = 1'b1;
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = ~bank_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg    <= MIN_LEN_RESET;
            position_reg   <= '0;
            in_run_reg     <= 1'b0;
            run_length_reg <= '0;
            run_start_reg  <= '0;
            halted_reg     <= 1'b0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_len_reg <= cfg_wdata;
            end
            position_reg   <= position_next;
            in_run_reg     <= in_run_next;
            run_length_reg <= run_length_next;
            run_start_reg  <= run_start_next;
            halted_reg     <= halted_next;
            bank_reg       <= bank_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

@@ rtl/rte_queue.sv @@
// Two-entry report queue between the front end and the readout side.
module rte_queue
    import rte_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rte_job_t push_job,
    output logic     full,
    input  logic     pop,
    output rte_job_t head,
    output logic     empty
);

    rte_job_t   slot_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/rte_back.sv @@
// Readout side: holds the run buffer and plays reports out last character first.
module rte_back
    import rte_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(MAX_LEN):0] wr_addr,
    input  logic [CHAR_W-1:0]        wr_data,
    input  rte_job_t                 q_head,
    input  logic                     q_empty,
    output logic                     q_pop,
    output rte_free_t                bank_free,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [TDATA_W-1:0]       m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    localparam int IDX_W = $clog2(MAX_LEN);

    typedef enum logic [2:0]
    {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_EMIT = 3'b100
    } rte_bstate_t;

    logic [CHAR_W-1:0] mem [0:(2**(IDX_W+1))-1];
    logic [CHAR_W-1:0] rd_data_reg;
    logic [IDX_W:0]    rd_addr;

    rte_bstate_t       state_reg, state_next;
    rte_job_t          job_reg, job_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    rte_kind_t         kind_reg, kind_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        rd_addr    = {job_reg.bank, idx_reg};
        q_pop      = 1'b0;
        bank_free  = '0;

        case (state_reg)
            B_IDLE:
            begin
                rd_addr = {q_head.bank, q_head.count[IDX_W-1:0] - IDX_W'(1)};
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    job_next = q_head;
                    idx_next = q_head.count[IDX_W-1:0] - IDX_W'(1);
                    if (q_head.kind == KIND_OVERFLOW)
                    begin
                        char_next  = '0;
                        last_next  = 1'b1;
                        kind_next  = KIND_OVERFLOW;
                        state_next = B_EMIT;
                    end
                    else
                    begin
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                char_next  = (rd_data_reg == SPACE_CH) ? FILL_CH : rd_data_reg;
                last_next  = (idx_reg == '0);
                kind_next  = KIND_RUN;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                rd_addr = {job_reg.bank, idx_reg - IDX_W'(1)};
                if (m_tready)
                begin
                    if (last_reg)
                    begin
                        bank_free.valid = (kind_reg == KIND_RUN);
                        bank_free.bank  = job_reg.bank;
                        state_next      = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
        last_reg <= last_next;
        kind_reg <= kind_next;
    end

    assign m_tvalid = (state_reg == B_EMIT);
    assign m_tdata  = {job_reg.end_addr, job_reg.start_addr, char_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/rom_text_run_extractor.sv @@
// Top level of the text run extractor: front end, report queue and readout side.
// Throughput: one byte request per cycle while the run's bank is free and the queue has room.
// A reported run is played out one character at a time, each read before it is shown.
// A report is queued, popped in B_IDLE and read in B_READ before its first character is valid.
// Reset (rst_n, asynchronous, active low) clears control state and sets min_len to 4.
// The run buffer is not cleared; no clearing pass is needed, so requests are taken at once.

module rom_text_run_extractor
    import rte_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int ADDR_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Byte request stream. s_tdata: byte_req [7:0].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,
    // Minimum reported run length register.
    input  logic                  cfg_we,
    input  logic [MIN_LEN_W-1:0]  cfg_wdata,
    // Report stream. m_tdata: character [7:0], start_addr [23:8], end_addr [39:24].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,
    // m_tuser: kind [0], zero for a run character, one for the overflow error.
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W = $clog2(MAX_LEN);

    logic              wr_en;
    logic [IDX_W:0]    wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    rte_job_t          q_job;
    rte_job_t          q_head;
    rte_free_t         bank_free;

    // The front end classifies each byte, writes text characters into the
    // bank that holds the current run and hands finished runs to the queue.
    // Two banks let a new run be collected while the previous one is read out.
    rte_front #(
        .MAX_LEN   (MAX_LEN),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_push    (q_push),
        .q_job     (q_job),
        .q_full    (q_full),
        .bank_free (bank_free)
    );

    // The queue decouples run detection from the slower character playout.
    rte_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // The readout side owns the buffer memory and walks each run backward,
    // releasing the bank after the final character is taken.
    rte_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .bank_free (bank_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("report pushed into a full queue");

    // The readout side never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("report popped from an empty queue");

    // An overflow error is always a single final item with a zero character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[CHAR_W-1:0] == '0)))
        else $error("malformed overflow item");

    // A bank is released only as the final character of a run report is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        bank_free.valid |-> (m_tvalid && m_tready && m_tlast && !m_tuser))
        else $error("buffer bank released outside the end of a report");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the text run extractor, with its own prediction of every report.
module tb
    import rte_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int RUN_CAP        = 64;    // run length at which the block overflows and halts
    localparam int HOLD_CYCLES    = 400;   // one long receiver hold-off to fill the block up
    localparam int DRAIN_CYCLES   = 12;    // settle time after the last report, covers latency
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no request moving on either side
    localparam int PRINT_CAP      = 30;    // mismatches shown before going quiet

    // One report item as it leaves the block.
    typedef struct packed
    {
        rte_kind_t             kind;
        logic [CHAR_W-1:0]     ch;
        logic [ADDR_OUT_W-1:0] start_addr;
        logic [ADDR_OUT_W-1:0] end_addr;
        logic                  last;
    } report_t;

    // Block ports. Every input holds a known value from time zero.
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata = '0;
    logic                  cfg_we = 1'b0;
    logic [MIN_LEN_W-1:0]  cfg_wdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;     // character [7:0], start_addr [23:8], end_addr [39:24]
    logic                  m_tuser;     // kind [0]
    logic                  m_tlast;

    // Knobs that the stimulus process sets and the driver and monitor read.
    logic gaps_on = 1'b0;
    logic stalls_on = 1'b0;
    logic hold_arm = 1'b0;

    // Byte requests waiting for the driver, and the reports the scanner model expects.
    logic [CHAR_W-1:0] pending_bytes[$];
    report_t           expected_reports[$];
    int                bytes_queued = 0;
    int                bytes_accepted = 0;
    int                fault_count = 0;

    // Generator bookkeeping: the length of the run open once all queued bytes are consumed.
    // It lets the stimulus keep runs below the overflow.
    int                    gen_run = 0;
    bit                    allow_overflow = 1'b0;

    // Scanner model state, advanced once per accepted byte request.
    logic [ADDR_OUT_W-1:0] scan_pos;
    logic                  scan_in_run;
    int                    scan_len;
    logic [ADDR_OUT_W-1:0] scan_start;
    logic [CHAR_W-1:0]     scan_buf[RUN_CAP];
    logic                  scan_halted;
    int                    scan_min_len;

    // Handshake timing state of the driver, the monitor and the watchdog.
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int idle_cycles = 0;

    rom_text_run_extractor #(
        .MAX_LEN   (RUN_CAP),
        .ADDR_BITS (ADDR_OUT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Text class: digits, capitals, space and the punctuation marks the scanner accepts.
    function automatic logic is_text_char(input logic [CHAR_W-1:0] c);
        case (c)
            "-", ":", "!", ",", ".", "'", "\"", "%", " ":
                return 1'b1;
            default:
                return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z");
        endcase
    endfunction

    // Idle length for either side: mostly none or short, now and then a long one.
    function automatic int pick_gap(input logic enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_text();
        logic [CHAR_W-1:0] c;
        do
            c = $urandom_range(0, 255);
        while (!is_text_char(c));
        return c;
    endfunction

    // A byte that ends a run. The blank code is left out, since inside a run it reads as space.
    function automatic logic [CHAR_W-1:0] pick_nontext();
        logic [CHAR_W-1:0] c;
        do
            c = $urandom_range(0, 255);
        while (is_text_char(c) || c == BLANK_IN_RUN);
        return c;
    endfunction

    // Print one report item with a leading tag.
    task automatic show_report(input string tag, input report_t r);
        $display("%0t: %s kind=%0d char=%h start=%0d end=%0d last=%0d",
                 $time, tag, r.kind, r.ch, r.start_addr, r.end_addr, r.last);
    endtask

    // Advance the scanner model by one accepted byte and queue the reports it causes.
    task automatic scan_byte(input logic [CHAR_W-1:0] raw);
        logic [CHAR_W-1:0] c;
        report_t           r;
        c = raw;
        if (scan_halted)
            return;
        // The blank code only counts as a space once a run has started.
        if (scan_in_run && c == BLANK_IN_RUN)
            c = SPACE_CH;
        if (is_text_char(c))
        begin
            if (scan_len < RUN_CAP)
                scan_buf[scan_len] = c;
            scan_len++;
            if (!scan_in_run)
            begin
                scan_start  = scan_pos;
                scan_in_run = 1'b1;
            end
            if (scan_len >= RUN_CAP)
            begin
                // Run buffer full: one error item, then the block ignores everything.
                r.kind       = KIND_OVERFLOW;
                r.ch         = '0;
                r.start_addr = scan_start;
                r.end_addr   = scan_pos;
                r.last       = 1'b1;
                expected_reports.push_back(r);
                scan_halted = 1'b1;
                return;
            end
        end
        else if (scan_in_run)
        begin
            if (scan_len >= scan_min_len)
            begin
                // The run is played out last character first, spaces shown as fill.
                for (int i = scan_len - 1; i >= 0; i--)
                begin
                    r.kind       = KIND_RUN;
                    r.ch         = (scan_buf[i] == SPACE_CH) ? FILL_CH : scan_buf[i];
                    r.start_addr = scan_start;
                    r.end_addr   = scan_pos - 1'b1;
                    r.last       = (i == 0);
                    expected_reports.push_back(r);
                end
            end
            scan_in_run = 1'b0;
            scan_len    = 0;
        end
        scan_pos = scan_pos + 1'b1;
    endtask

    // Queue one byte request. Unless an overflow is wanted, a run about to reach the
    // buffer size is closed first with a terminating byte.
    task automatic queue_byte(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] seq[$];
        if (!allow_overflow && gen_run == RUN_CAP - 1 &&
            (is_text_char(b) || b == BLANK_IN_RUN))
            seq.push_back(8'h00);
        seq.push_back(b);
        foreach (seq[i])
        begin
            if (is_text_char(seq[i]) || (gen_run > 0 && seq[i] == BLANK_IN_RUN))
                gen_run++;
            else
                gen_run = 0;
            bytes_queued++;
            pending_bytes.push_back(seq[i]);
        end
    endtask

    task automatic queue_str(input string s);
        foreach (s[i])
            queue_byte(s[i]);
    endtask

    // A well-formed run of random text with the odd blank code inside, then its terminator.
    task automatic queue_run(input int len);
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(0, 99) < 15)
                queue_byte(BLANK_IN_RUN);
            else
                queue_byte(pick_text());
        end
        queue_byte(pick_nontext());
    endtask

    // Random traffic: mostly complete runs of varied length, the rest raw noise bytes.
    // It always leaves the stream outside a run so the next phase starts clean.
    task automatic queue_mix(input int n);
        int stop_at;
        int roll;
        int len;
        stop_at = bytes_queued + n;
        while (bytes_queued < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    len = $urandom_range(1, 10);
                else if (roll < 95)
                    len = $urandom_range(11, 30);
                else
                    len = $urandom_range(31, RUN_CAP - 1);
                queue_run(len);
            end
            else
                queue_byte($urandom_range(0, 255));
        end
        if (gen_run > 0)
            queue_byte(pick_nontext());
    endtask

    // Wait until every queued request is taken and every expected report has come back,
    // then give bytes that cause no report time to clear the pipeline.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_accepted != bytes_queued || expected_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Start a phase: write min_len while the block is idle and set the idling knobs.
    task automatic begin_phase(input int len, input logic idle);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len[MIN_LEN_W-1:0];
        @(posedge clk);
        cfg_we       <= 1'b0;
        scan_min_len = len;
        gaps_on      <= idle;
        stalls_on    <= idle;
        @(negedge clk);
    endtask

    // Driver: presents queued bytes on the request side, with random gaps between them.
    // Every accepted byte goes through the scanner model at the edge that takes it.
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        logic              next_valid;
        logic [CHAR_W-1:0] next_byte;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left = 0;
        end
        else
        begin
            next_valid = s_tvalid;
            next_byte  = s_tdata;
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata);
                bytes_accepted++;
                next_valid = 1'b0;
            end
            // Valid is computed once so a back-to-back request never sees a low pulse.
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_bytes.size() != 0)
                begin
                    next_byte  = pending_bytes.pop_front();
                    next_valid = 1'b1;
                    gap_left   = pick_gap(gaps_on);
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_byte;
        end
    end

    // Monitor: takes report items, compares each field with the oldest expectation,
    // and throttles ready with random stalls plus one long hold-off when armed.
    always @(posedge clk or negedge rst_n)
    begin : report_monitor
        report_t got;
        report_t want;
        logic    next_ready;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind       = rte_kind_t'(m_tuser);
                got.ch         = m_tdata[7:0];
                got.start_addr = m_tdata[23:8];
                got.end_addr   = m_tdata[39:24];
                got.last       = m_tlast;
                if (expected_reports.size() == 0)
                begin
                    if (fault_count < PRINT_CAP)
                        show_report("unexpected report:", got);
                    fault_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.kind !== want.kind || got.ch !== want.ch ||
                        got.start_addr !== want.start_addr || got.end_addr !== want.end_addr ||
                        got.last !== want.last)
                    begin
                        if (fault_count < PRINT_CAP)
                        begin
                            show_report("report mismatch, expected", want);
                            show_report("                   actual", got);
                        end
                        fault_count++;
                    end
                end
            end
            if (hold_arm && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
            begin
                // A fresh stall starts now, so this cycle is its first.
                stall_left = pick_gap(stalls_on);
                next_ready = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
            m_tready <= next_ready;
        end
    end

    // Watchdog: a long stretch with no request moving on either side means the block hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** rom_text_run_extractor: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: directed checks first, then random phases across min_len settings,
    // and finally the overflow that halts the block.
    initial
    begin
        // The scanner model starts from the reset state of the block.
        scan_pos     = '0;
        scan_in_run  = 1'b0;
        scan_len     = 0;
        scan_start   = '0;
        scan_halted  = 1'b0;
        scan_min_len = MIN_LEN_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset value of min_len and no idling. A run exactly min_len long with
        // a blank code inside, a blank code outside any run, a run one short, a run of
        // every punctuation mark with a leading space, and the neighbors of the text class.
        queue_byte(8'h00);
        queue_str("A-");
        queue_byte(BLANK_IN_RUN);
        queue_str("9");
        queue_byte(8'h7F);
        queue_byte(BLANK_IN_RUN);
        queue_str("QRS");
        queue_byte(8'h80);
        queue_str(" :!,.'\"%0Z");
        queue_byte(8'h2F);
        queue_str("@[a");

        // min_len of one reports every run, even a lone space.
        begin_phase(1, 1'b1);
        queue_str("X");
        queue_byte(8'h00);
        queue_str(" ");
        queue_byte(8'h01);
        queue_str("Y");
        queue_byte(BLANK_IN_RUN);
        queue_byte(8'hFE);
        queue_mix(20);

        // min_len of zero behaves like one; this stretch runs with no idling at all.
        begin_phase(0, 1'b0);
        queue_mix(20);

        // min_len at the buffer size and at its top value: nothing is ever reported,
        // not even the longest run that still fits.
        begin_phase(RUN_CAP, 1'b1);
        queue_run(RUN_CAP - 1);
        queue_mix(10);
        begin_phase(127, 1'b1);
        queue_mix(8);

        // The longest report the block can produce.
        begin_phase(RUN_CAP - 1, 1'b1);
        queue_run(RUN_CAP - 1);
        queue_mix(10);

        // Main random phase. The receiver holds off once for a long stretch while
        // requests keep coming, so the buffer banks fill and the input side stalls.
        begin_phase($urandom_range(2, 10), 1'b1);
        queue_mix(40);
        hold_arm <= 1'b1;

        // A short run with a blank code inside, with min_len three and no idling.
        begin_phase(3, 1'b0);
        queue_str("SP");
        queue_byte(BLANK_IN_RUN);
        queue_str("N!");
        queue_byte(8'h0D);

        // Random traffic, then a run exactly min_len long sent with no gaps.
        begin_phase(5, 1'b1);
        queue_mix(15);
        gaps_on <= 1'b0;
        queue_str("EN");
        queue_byte(BLANK_IN_RUN);
        queue_str("D.");
        queue_byte(8'hC3);

        // Last phase: a run that fills the buffer overflows and halts the block; the
        // bytes after it, runs and terminators alike, must produce nothing.
        begin_phase(2, 1'b1);
        queue_mix(10);
        allow_overflow = 1'b1;
        queue_run(RUN_CAP);
        queue_str("AB");
        queue_byte(8'h00);
        queue_str("C D");
        queue_byte(8'h5B);

        wait_drained();
        if (expected_reports.size() != 0)
            $display("%0t: %0d expected reports never arrived", $time, expected_reports.size());
        if (fault_count == 0 && expected_reports.size() == 0)
            $display("** rom_text_run_extractor: PASSED **");
        else
            $display("** rom_text_run_extractor: FAILED **");
        $finish;
    end

endmodule
